[rtl/core/tmq_pkg.sv]
// Shared types and constants for the timestamp match queue.
package tmq_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [2:0] EV_INSERT = 3'd0;
    localparam logic [2:0] EV_EVICT  = 3'd1;
    localparam logic [2:0] EV_MATCH  = 3'd2;
    localparam logic [2:0] EV_MISS   = 3'd3;
    localparam logic [2:0] EV_CLEAR  = 3'd4;

    localparam int STAMP_W = 32;
    localparam int META_PORT_W = 32;
    localparam int CNT_PORT_W = 4;
    localparam int EVENT_W = 3;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic ins;
        logic clr;
        logic scan_start;
        logic scan_step;
        logic lk_done;
    } tmq_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic empty;
        logic hit_eq;
        logic hit_newer;
        logic last;
        logic out_free;
    } tmq_stat_t;

endpackage

[rtl/core/tmq_ram.sv]
// Generic single write, single read RAM with registered read data.
module tmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 10
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/tmq_ctrl.sv]
// Sequencing state machine for the timestamp match queue.
module tmq_ctrl
    import tmq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic [1:0] cmd,
    input  tmq_stat_t stat,
    output logic      in_ready,
    output tmq_cmd_t  ctl
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INS    = 3'd1;
    localparam logic [2:0] S_CLR    = 3'd2;
    localparam logic [2:0] S_LSTART = 3'd3;
    localparam logic [2:0] S_LCMP   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load = 1'b1;
                    case (cmd)
                        CMD_INSERT: state_next = S_INS;
                        CMD_LOOKUP: state_next = S_LSTART;
                        CMD_CLEAR:  state_next = S_CLR;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_INS:
            begin
                if (stat.out_free)
                begin
                    ctl.ins    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CLR:
            begin
                if (stat.out_free)
                begin
                    ctl.clr    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_LSTART:
            begin
                if (stat.empty)
                begin
                    if (stat.out_free)
                    begin
                        ctl.lk_done = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    ctl.scan_start = 1'b1;
                    state_next     = S_LCMP;
                end
            end
            S_LCMP:
            begin
                // stop on a match, a newer entry or the last entry
                if (stat.hit_eq || stat.hit_newer || stat.last)
                begin
                    if (stat.out_free)
                    begin
                        ctl.lk_done = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    ctl.scan_step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/tmq_dp.sv]
// Datapath: record stores, ring pointers, scan compare and result register.
module tmq_dp
    import tmq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 10,
    parameter int META_WIDTH  = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tmq_cmd_t               ctl,
    output tmq_stat_t              stat,
    input  logic [STAMP_W-1:0]     stamp,
    input  logic [META_PORT_W-1:0] meta_in,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic                   found,
    output logic [META_PORT_W-1:0] meta_out,
    output logic [CNT_PORT_W-1:0]  dropped,
    output logic [CNT_PORT_W-1:0]  occupancy,
    output logic [EVENT_W-1:0]     event_res
);

    localparam int AW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int SUMW = CW + 1;
    localparam int SW   = (META_WIDTH < META_PORT_W) ? META_WIDTH : META_PORT_W;

    logic [AW-1:0]      head_reg;
    logic [AW-1:0]      head_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [AW-1:0]      ptr_reg;
    logic [CW-1:0]      idx_reg;
    logic [STAMP_W-1:0] key_reg;
    logic [SW-1:0]      meta_reg;

    logic                   out_valid_reg;
    logic                   found_reg;
    logic [META_PORT_W-1:0] meta_out_reg;
    logic [CNT_PORT_W-1:0]  dropped_reg;
    logic [CNT_PORT_W-1:0]  occupancy_reg;
    logic [EVENT_W-1:0]     event_reg;

    logic [STAMP_W-1:0] rd_stamp;
    logic [SW-1:0]      rd_meta;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      head_inc;
    logic [AW-1:0]      ptr_inc;
    logic [SUMW-1:0]    tail_sum;
    logic [CW-1:0]      idx_inc;
    logic [STAMP_W-1:0] diff;
    logic               full;
    logic               commit;
    logic               res_found;
    logic [SW-1:0]      res_meta;
    logic [CW-1:0]      res_drop;
    logic [EVENT_W-1:0] res_event;
    logic [CW+CNT_PORT_W-1:0]  drop_ext;
    logic [CW+CNT_PORT_W-1:0]  occ_ext;
    logic [SW+META_PORT_W-1:0] meta_ext;

    assign full     = (count_reg == CW'(QUEUE_DEPTH));
    assign head_inc = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign ptr_inc  = (ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : ptr_reg + AW'(1);
    assign idx_inc  = idx_reg + CW'(1);
    assign tail_sum = SUMW'(head_reg) + SUMW'(count_reg);

    // slot after the newest record; on overflow the evicted slot is reused
    always_comb
    begin
        if (full)
        begin
            wr_addr = head_reg;
        end
        else if (tail_sum >= SUMW'(QUEUE_DEPTH))
        begin
            wr_addr = AW'(tail_sum - SUMW'(QUEUE_DEPTH));
        end
        else
        begin
            wr_addr = tail_sum[AW-1:0];
        end
    end

    assign rd_addr = ctl.scan_start ? head_reg : ptr_inc;

    tmq_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (ctl.ins),
        .waddr (wr_addr),
        .wdata (key_reg),
        .re    (ctl.scan_start | ctl.scan_step),
        .raddr (rd_addr),
        .rdata (rd_stamp)
    );

    tmq_ram #(
        .WIDTH (SW),
        .DEPTH (QUEUE_DEPTH)
    ) u_meta_ram (
        .clk   (clk),
        .we    (ctl.ins),
        .waddr (wr_addr),
        .wdata (meta_reg),
        .re    (ctl.scan_start | ctl.scan_step),
        .raddr (rd_addr),
        .rdata (rd_meta)
    );

    // wraparound order: half-range distance falls back to plain magnitude
    assign diff = rd_stamp - key_reg;
    always_comb
    begin
        stat.hit_eq = (rd_stamp == key_reg);
        if (diff == {1'b1, {(STAMP_W-1){1'b0}}})
        begin
            stat.hit_newer = (rd_stamp > key_reg);
        end
        else
        begin
            stat.hit_newer = !stat.hit_eq && !diff[STAMP_W-1];
        end
        stat.empty    = (count_reg == '0);
        stat.last     = (idx_inc == count_reg);
        stat.out_free = !out_valid_reg || out_ready;
    end

    assign commit = ctl.ins | ctl.clr | ctl.lk_done;

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        res_found  = 1'b0;
        res_meta   = '0;
        res_drop   = '0;
        res_event  = EV_MISS;
        if (ctl.ins)
        begin
            if (full)
            begin
                head_next = head_inc;
                res_drop  = CW'(1);
                res_event = EV_EVICT;
            end
            else
            begin
                count_next = count_reg + CW'(1);
                res_event  = EV_INSERT;
            end
        end
        else if (ctl.clr)
        begin
            head_next  = '0;
            count_next = '0;
            res_drop   = count_reg;
            res_event  = EV_CLEAR;
        end
        else if (ctl.lk_done && !stat.empty)
        begin
            if (stat.hit_eq)
            begin
                head_next  = ptr_inc;
                count_next = count_reg - idx_inc;
                res_found  = 1'b1;
                res_meta   = rd_meta;
                res_drop   = idx_reg;
                res_event  = EV_MATCH;
            end
            else if (stat.hit_newer)
            begin
                head_next  = ptr_reg;
                count_next = count_reg - idx_reg;
                res_drop   = idx_reg;
            end
            else
            begin
                // ran off the end: everything scanned is stale
                head_next  = ptr_inc;
                count_next = '0;
                res_drop   = count_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign drop_ext = {{CNT_PORT_W{1'b0}}, res_drop};
    assign occ_ext  = {{CNT_PORT_W{1'b0}}, count_next};
    assign meta_ext = {{META_PORT_W{1'b0}}, res_meta};

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            key_reg  <= stamp;
            meta_reg <= meta_in[SW-1:0];
        end
        if (ctl.scan_start)
        begin
            ptr_reg <= head_reg;
            idx_reg <= '0;
        end
        else if (ctl.scan_step)
        begin
            ptr_reg <= ptr_inc;
            idx_reg <= idx_inc;
        end
        if (commit)
        begin
            found_reg     <= res_found;
            meta_out_reg  <= meta_ext[META_PORT_W-1:0];
            dropped_reg   <= drop_ext[CNT_PORT_W-1:0];
            occupancy_reg <= occ_ext[CNT_PORT_W-1:0];
            event_reg     <= res_event;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign meta_out  = meta_out_reg;
    assign dropped   = dropped_reg;
    assign occupancy = occupancy_reg;
    assign event_res = event_reg;

endmodule

[rtl/core/timestamp_match_queue_core.sv]
// Top level of the timestamp match queue: controller plus datapath.
//
// Bounded FIFO of frame records (timestamp plus metadata) matched against decoded
// timestamps under 32-bit wraparound order. One transaction is worked on at a time
// and each accepted command except the unused code gives exactly one result.
// An insert or clear is accepted in the idle state and its result is registered from
// S_INS or S_CLR once the output register is free. A lookup loads its stamp, starts
// the scan in S_LSTART and compares entries in S_LCMP, examining at most QUEUE_DEPTH
// entries; the scan reads one entry per cycle through the single read port of the
// record stores. A finished result waits in the output register while the next
// transaction is accepted; processing stalls only when a new result is ready and the
// previous one has not been taken. Record stores need no clearing after reset.
module timestamp_match_queue_core
    import tmq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 10,
    parameter int META_WIDTH  = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             cmd,
    input  logic [STAMP_W-1:0]     stamp,
    input  logic [META_PORT_W-1:0] meta_in,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   found,
    output logic [META_PORT_W-1:0] meta_out,
    output logic [CNT_PORT_W-1:0]  dropped,
    output logic [CNT_PORT_W-1:0]  occupancy,
    output logic [EVENT_W-1:0]     event_res
);

    tmq_cmd_t  ctl;
    tmq_stat_t stat;

    tmq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cmd      (cmd),
        .stat     (stat),
        .in_ready (in_ready),
        .ctl      (ctl)
    );

    tmq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .META_WIDTH  (META_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .stamp     (stamp),
        .meta_in   (meta_in),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .found     (found),
        .meta_out  (meta_out),
        .dropped   (dropped),
        .occupancy (occupancy),
        .event_res (event_res)
    );

endmodule
